// ===== hdl/smpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and constants of the sorted priority queue
// Value and count widths, operation and status codes, and the control
// bundle that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IO_WIDTH    = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OCC_W       = 5;
    localparam int STATUS_W    = 2;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic signed [IO_WIDTH-1:0]    t_io_value;
    typedef logic [CNT_W-1:0]              t_count;
    typedef logic [OCC_W-1:0]              t_occ;
    typedef logic [STATUS_W-1:0]           t_status;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam t_io_value EMPTY_VALUE = -32'sd1;
    localparam t_count    FULL_COUNT  = t_count'(CAPACITY);

    // Broadcast to all cells in the cycle of a transfer.
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_value new_value;
    } t_cell_ctrl;

    // Sign-extend or wrap an input value to the stored width.
    function automatic t_value to_stored(input t_io_value v);
        return t_value'(v);
    endfunction

    // Low bits of a stored value, sign-extended when the store is narrow.
    function automatic t_io_value to_io(input t_value v);
        return t_io_value'(v);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/smpq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_if: valid/ready channels of the sorted priority queue
// One interface for the operation requests and one for the results.
// ----------------------------------------------------------------------------
interface smpq_in_if;
    import smpq_pkg::*;

    logic      valid;
    logic      ready;
    logic      operation;
    t_io_value value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface smpq_out_if;
    import smpq_pkg::*;

    logic      valid;
    logic      ready;
    t_io_value removed_value;
    t_status   status;
    t_occ      occupancy;

    modport source (output valid, output removed_value, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input removed_value, input status,
                    input occupancy, output ready);
endinterface
`default_nettype wire

// ===== hdl/smpq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted chain
// Holds one value, reports whether it outranks the incoming value, and on an
// insert keeps, takes the new value or takes its left neighbor's value; on a
// remove it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module smpq_cell (
    input  wire logic                  i_clk,
    input  wire smpq_pkg::t_cell_ctrl  i_ctrl,
    input  wire logic                  i_occ,
    input  wire logic                  i_left_ge,
    input  wire smpq_pkg::t_value      i_left_value,
    input  wire smpq_pkg::t_value      i_right_value,
    output logic                       o_ge,
    output smpq_pkg::t_value           o_value
);
    import smpq_pkg::*;

    t_value r_value;
    t_value n_value;

    // Equal values stay ahead of the newcomer.
    assign o_ge    = i_occ && (r_value >= i_ctrl.new_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins) begin
            if (o_ge) begin
                n_value = r_value;
            end else if (i_left_ge) begin
                n_value = i_ctrl.new_value;
            end else begin
                n_value = i_left_value;
            end
        end else if (i_ctrl.rem) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

// ===== hdl/sorted_max_priority_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_max_priority_queue_top: bounded max-first priority queue
// A chain of cells keeps up to CAPACITY signed values sorted from largest to
// smallest; inserts land in order and removes return the largest value.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the i_in channel (operation, value) and results leave on
// the o_out channel (removed_value, status, occupancy). Every request transfer
// produces exactly one result transfer, in order.
// An insert compares the new value against every cell at once; each cell then
// keeps its value, takes the new one, or takes its left neighbor's, so the
// list shifts right by one behind the insertion point. A remove shifts the
// whole chain left by one and returns the head cell.
// The result is loaded into the output register at the edge of the request
// transfer and can be transferred from the cycle after on.
// Throughput is one item per cycle while the receiver takes results, as the
// compare-and-shift in the cell chain is done in the cycle of the transfer.
// A new request is taken whenever the output register is empty or its result
// is being transferred in the same cycle, so a stalled receiver holds off the
// sender after one buffered result and no result is lost.
// A remove on an empty queue returns -1 with the empty status; an insert on a
// full queue is dropped with the full status and the count is unchanged.
// Reset clears the count and the output valid; stored values need no reset,
// since only cells below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    smpq_in_if.sink   i_in,
    smpq_out_if.source o_out
);
    import smpq_pkg::*;

    t_count      r_count;
    t_count      n_count;
    logic        r_out_valid;
    t_io_value   r_removed;
    t_status     r_status;
    t_occ        r_occ;
    t_io_value   n_removed;
    t_status     n_status;

    logic        accept;
    logic        is_full;
    logic        is_empty;
    t_cell_ctrl  ctrl;

    logic   [CAPACITY-1:0] cell_ge;
    logic   [CAPACITY-1:0] cell_occ;
    t_value                cell_value [CAPACITY];

    // The output register accepts a new result when empty or draining.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_full    = (r_count == FULL_COUNT);
    assign is_empty   = (r_count == '0);

    assign ctrl.ins       = accept && (i_in.operation == OP_INSERT) && !is_full;
    assign ctrl.rem       = accept && (i_in.operation == OP_REMOVE) && !is_empty;
    assign ctrl.new_value = to_stored(i_in.value);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign cell_occ[g] = (t_count'(g) < r_count);

        smpq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occ         (cell_occ[g]),
            .i_left_ge     ((g == 0) ? 1'b1 : cell_ge[(g == 0) ? 0 : g - 1]),
            .i_left_value  (cell_value[(g == 0) ? 0 : g - 1]),
            .i_right_value (cell_value[(g == CAPACITY - 1) ? g : g + 1]),
            .o_ge          (cell_ge[g]),
            .o_value       (cell_value[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_removed = '0;
        n_status  = ST_OK;
        if (i_in.operation == OP_REMOVE) begin
            if (is_empty) begin
                n_removed = EMPTY_VALUE;
                n_status  = ST_EMPTY;
            end else begin
                n_removed = to_io(cell_value[0]);
                n_count   = r_count - t_count'(1);
            end
        end else begin
            if (is_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed <= n_removed;
            r_status  <= n_status;
            r_occ     <= t_occ'(n_count);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = r_removed;
    assign o_out.status        = r_status;
    assign o_out.occupancy     = r_occ;

endmodule
`default_nettype wire
